@@ rtl/aabb_collision_query_table_unit_macros.svh @@
// ----------------------------------------------------------------------------
// aabb collision query table: assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AABB_COLLISION_QUERY_TABLE_UNIT_MACROS_SVH
`define AABB_COLLISION_QUERY_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ACQT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acqt assertion failed");
`define ACQT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acqt assertion failed");
`else
`define ACQT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ACQT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/acqt_pkg.sv @@
// ----------------------------------------------------------------------------
// acqt_pkg
// Types and constants shared by the collision query table modules.
// ----------------------------------------------------------------------------
package acqt_pkg;

    localparam int CW        = 18;
    localparam int NUM_TYPES = 9;
    localparam int MASK_BITS = 81;
    localparam int MASK_IW   = $clog2(MASK_BITS);
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;
    localparam int QDEPTH    = 2;
    localparam int QPW       = $clog2(QDEPTH);

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [2:0] STAT_HIT     = 3'd0;
    localparam logic [2:0] STAT_ADDED   = 3'd1;
    localparam logic [2:0] STAT_REMOVED = 3'd2;
    localparam logic [2:0] STAT_FULL    = 3'd3;
    localparam logic [2:0] STAT_DONE    = 3'd4;

    localparam logic [1:0] REG_AREA_MARGIN = 2'd0;
    localparam logic [1:0] REG_MASK_LOW    = 2'd1;
    localparam logic [1:0] REG_MASK_HIGH   = 2'd2;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         slot;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_w;
        logic [14:0]        rect_h;
        logic [3:0]         body_class;
        logic               has_callback;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] result_slot;
        logic [3:0] hit_type;
        logic       notify_query;
        logic       notify_other;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] slot;
        t_coord     x;
        t_coord     y;
        t_coord     xr;
        t_coord     yb;
        t_coord     nx_hi;
        t_coord     nx_lo;
        t_coord     ny_hi;
        t_coord     ny_lo;
        logic [3:0] ctype;
        logic       cb;
    } t_cmd;

    typedef struct packed {
        t_coord     x;
        t_coord     y;
        t_coord     xr;
        t_coord     yb;
        logic [3:0] ctype;
        logic       cb;
    } t_entry;

endpackage

@@ rtl/acqt_front.sv @@
// ----------------------------------------------------------------------------
// acqt_front
// Accepts input items, drops unknown kinds and precomputes rectangle edges
// and margin-widened bounds for the back end.
// ----------------------------------------------------------------------------
module acqt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  acqt_pkg::t_in i_in,
    input  logic [11:0]   i_margin,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output acqt_pkg::t_cmd o_cmd
);
    import acqt_pkg::*;

    logic   r_v;
    t_cmd   r_cmd;
    t_cmd   n_cmd;
    logic   w_accept;
    t_coord w_m;

    assign o_in_ready  = !r_v || i_cmd_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_cmd_valid = r_v;
    assign o_cmd       = r_cmd;
    assign w_m         = t_coord'(i_margin);

    always_comb begin
        n_cmd       = '0;
        n_cmd.op    = i_in.kind;
        n_cmd.slot  = i_in.slot;
        n_cmd.x     = t_coord'(i_in.rect_x);
        n_cmd.y     = t_coord'(i_in.rect_y);
        n_cmd.xr    = t_coord'(i_in.rect_x) + t_coord'(i_in.rect_w);
        n_cmd.yb    = t_coord'(i_in.rect_y) + t_coord'(i_in.rect_h);
        n_cmd.nx_hi = t_coord'(i_in.rect_x) + w_m;
        n_cmd.nx_lo = t_coord'(i_in.rect_x) - w_m;
        n_cmd.ny_hi = n_cmd.yb + w_m;
        n_cmd.ny_lo = t_coord'(i_in.rect_y) - w_m;
        n_cmd.ctype = i_in.body_class;
        n_cmd.cb    = i_in.has_callback;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_accept) begin
            r_v <= (i_in.kind != KIND_NONE);
        end else if (i_cmd_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ rtl/acqt_fifo.sv @@
// ----------------------------------------------------------------------------
// acqt_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module acqt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  acqt_pkg::t_cmd i_data,
    output logic           o_valid,
    input  logic           i_pop,
    output acqt_pkg::t_cmd o_data
);
    import acqt_pkg::*;

    localparam logic [QPW:0] FULL = (QPW + 1)'(QDEPTH);

    t_cmd           r_mem [QDEPTH];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QPW:0]   r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_ready = (r_cnt != FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/acqt_back.sv @@
// ----------------------------------------------------------------------------
// acqt_back
// Executes commands: slot allocation scan, remove, and the pipelined query
// scan over the rectangle memory with overlap tests and pair filtering.
// ----------------------------------------------------------------------------
`include "aabb_collision_query_table_unit_macros.svh"

module acqt_back #(
    parameter int SLOTS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_pop,
    input  acqt_pkg::t_cmd                 i_cmd,
    input  logic [acqt_pkg::MASK_BITS-1:0] i_pair_mask,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output acqt_pkg::t_out                 o_out
);
    import acqt_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int IW = (SW > 5) ? SW : 5;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ADD   = 2'd1;
    localparam logic [1:0] ST_QUERY = 2'd2;
    localparam logic [1:0] ST_QDONE = 2'd3;

    function automatic logic f_allowed(input logic [3:0] row, input logic [3:0] col,
                                       input logic [MASK_BITS-1:0] mask);
        logic [7:0] idx;
        idx = 8'(row) * 8'(NUM_TYPES) + 8'(col);
        return (32'(row) < NUM_TYPES) && (32'(col) < NUM_TYPES) &&
               (32'(idx) < MASK_BITS) && mask[idx[MASK_IW-1:0]];
    endfunction

    logic [1:0]       r_state;
    logic [SW-1:0]    r_idx;
    t_cmd             r_cmd;
    logic [SLOTS-1:0] r_valid;
    t_entry           r_mem [SLOTS];
    t_entry           r_rd;
    logic             r_s1_v;
    logic             r_s1_done;
    logic             r_s1_chk;
    logic [SW-1:0]    r_s1_idx;
    logic             r_s2_v;
    logic             r_s2_done;
    logic             r_s2_hit;
    logic [SW-1:0]    r_s2_idx;
    logic [3:0]       r_s2_type;
    logic             r_s2_cb;
    logic             r_out_v;
    t_out             r_out;

    logic   w_adv;
    logic   w_pop;
    logic   w_last_idx;
    logic   w_free;
    logic   w_issue;
    logic   w_near;
    logic   w_ovl;
    logic   w_nq;
    logic   w_no;
    logic   n_emit;
    t_out   n_res;
    t_entry w_new;

    assign w_adv      = !r_out_v || i_out_ready;
    assign w_pop      = (r_state == ST_IDLE) && i_cmd_valid && !r_s1_v && !r_s2_v && w_adv;
    assign w_last_idx = (r_idx == SW'(SLOTS - 1));
    assign w_free     = !r_valid[r_idx];
    assign w_issue    = w_adv && ((r_state == ST_QUERY) || (r_state == ST_QDONE));
    assign o_cmd_pop  = w_pop;
    assign o_out_valid = r_out_v;
    assign o_out      = r_out;

    assign w_new.x     = r_cmd.x;
    assign w_new.y     = r_cmd.y;
    assign w_new.xr    = r_cmd.xr;
    assign w_new.yb    = r_cmd.yb;
    assign w_new.ctype = r_cmd.ctype;
    assign w_new.cb    = r_cmd.cb;

    assign w_near = (r_rd.x <= r_cmd.nx_hi) && (r_rd.xr >= r_cmd.nx_lo) &&
                    (r_rd.y <= r_cmd.ny_hi) && (r_rd.yb >= r_cmd.ny_lo);
    assign w_ovl  = (r_cmd.x < r_rd.xr) && (r_cmd.xr > r_rd.x) &&
                    (r_cmd.y < r_rd.yb) && (r_cmd.yb > r_rd.y);

    assign w_nq = r_cmd.cb && f_allowed(r_cmd.ctype, r_s2_type, i_pair_mask);
    assign w_no = r_s2_cb && f_allowed(r_s2_type, r_cmd.ctype, i_pair_mask);

    always_comb begin
        n_emit = 1'b0;
        n_res  = '0;
        if (w_pop && (i_cmd.op == KIND_REMOVE)) begin
            n_emit            = 1'b1;
            n_res.status      = STAT_REMOVED;
            n_res.result_slot = i_cmd.slot;
            n_res.last        = 1'b1;
        end
        if ((r_state == ST_ADD) && w_adv) begin
            if (w_free) begin
                n_emit            = 1'b1;
                n_res.status      = STAT_ADDED;
                n_res.result_slot = 5'(r_idx);
                n_res.last        = 1'b1;
            end else if (w_last_idx) begin
                n_emit       = 1'b1;
                n_res.status = STAT_FULL;
                n_res.last   = 1'b1;
            end
        end
        if (w_adv && r_s2_v) begin
            if (r_s2_done) begin
                n_emit            = 1'b1;
                n_res.status      = STAT_DONE;
                n_res.result_slot = r_cmd.slot;
                n_res.last        = 1'b1;
            end else if (r_s2_hit && (w_nq || w_no)) begin
                n_emit             = 1'b1;
                n_res.status       = STAT_HIT;
                n_res.result_slot  = 5'(r_s2_idx);
                n_res.hit_type     = r_s2_type;
                n_res.notify_query = w_nq;
                n_res.notify_other = w_no;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_valid <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_pop) begin
                        r_idx <= '0;
                        case (i_cmd.op)
                            KIND_ADD:    r_state <= ST_ADD;
                            KIND_QUERY:  r_state <= ST_QUERY;
                            KIND_REMOVE: begin
                                if (32'(i_cmd.slot) < SLOTS) begin
                                    r_valid[SW'(i_cmd.slot)] <= 1'b0;
                                end
                            end
                            default:     r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_ADD: begin
                    if (w_adv) begin
                        if (w_free) begin
                            r_valid[r_idx] <= 1'b1;
                            r_state        <= ST_IDLE;
                        end else if (w_last_idx) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_QUERY: begin
                    if (w_adv) begin
                        if (w_last_idx) begin
                            r_state <= ST_QDONE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_QDONE: begin
                    if (w_adv) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_ADD) && w_adv && w_free) begin
            r_mem[r_idx] <= w_new;
        end
        if (w_issue) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v  <= w_issue;
            r_s2_v  <= r_s1_v;
            r_out_v <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_done <= (r_state == ST_QDONE);
            r_s1_chk  <= r_valid[r_idx] && (IW'(r_idx) != IW'(r_cmd.slot));
            r_s1_idx  <= r_idx;
            r_s2_done <= r_s1_done;
            r_s2_hit  <= r_s1_chk && w_near && w_ovl;
            r_s2_idx  <= r_s1_idx;
            r_s2_type <= r_rd.ctype;
            r_s2_cb   <= r_rd.cb;
            if (n_emit) begin
                r_out <= n_res;
            end
        end
    end

    `ACQT_ASSERT_IMP(a_done_after_scan, i_clk, i_rst_n, r_s1_v && r_s1_done, r_state == ST_IDLE)
    `ACQT_ASSERT_NXT(a_scan_holds, i_clk, i_rst_n, (r_state == ST_QUERY) && !w_adv, $stable(r_idx))
    `ACQT_ASSERT_IMP(a_last_flag, i_clk, i_rst_n, r_out_v, r_out.last == (r_out.status != STAT_HIT))
    `ACQT_ASSERT_IMP(a_hit_notifies, i_clk, i_rst_n, r_out_v && (r_out.status == STAT_HIT), r_out.notify_query || r_out.notify_other)

endmodule

@@ rtl/aabb_collision_query_table_unit.sv @@
// ----------------------------------------------------------------------------
// aabb_collision_query_table_unit
// Rectangle collision table with near/overlap tests and type-pair filtering.
// ----------------------------------------------------------------------------
// usage:
//   input items (valid/ready) carry add, remove or query commands; kind 3 is
//   taken and dropped. result items (valid/ready) carry status, slot, type,
//   notify flags and a last marker on the final result of each command.
//   area margin and the 81-bit pair mask are written over the apb port at
//   byte addresses 0, 8 and 16; reads return them. the user must write them
//   only while the block is idle; the block does not enforce it. add scans
//   the slot valid bits one slot a cycle while the result output is not
//   stalled. a query streams every slot through a three-stage memory read /
//   compare / filter pipeline at one slot a cycle while results are not
//   stalled; the back end takes no new command until that pipeline has
//   drained. a front register and a two-entry queue take further items while
//   the back end works. when the receiver stalls, the scan freezes in place
//   and the pending result holds; nothing is lost.
//   reset clears valid bits, apb registers and state; no clearing pass is run.
// ----------------------------------------------------------------------------
module aabb_collision_query_table_unit #(
    parameter int SLOTS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  acqt_pkg::t_in               i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output acqt_pkg::t_out              o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [acqt_pkg::ADDR_W-1:0] paddr,
    input  logic [acqt_pkg::DATA_W-1:0] pwdata,
    output logic [acqt_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import acqt_pkg::*;

    logic [11:0] r_margin;
    logic [63:0] r_mask_lo;
    logic [16:0] r_mask_hi;
    logic        w_wr;
    logic [1:0]  w_reg;
    logic        w_f_valid;
    logic        w_f_ready;
    t_cmd        w_f_cmd;
    logic        w_q_valid;
    logic        w_q_pop;
    t_cmd        w_q_cmd;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[ADDR_W-1:ADDR_W-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin  <= '0;
            r_mask_lo <= '0;
            r_mask_hi <= '0;
        end else if (w_wr) begin
            case (w_reg)
                REG_AREA_MARGIN: r_margin  <= pwdata[11:0];
                REG_MASK_LOW:    r_mask_lo <= pwdata;
                REG_MASK_HIGH:   r_mask_hi <= pwdata[16:0];
                default:         r_margin  <= r_margin;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_AREA_MARGIN: prdata = 64'(r_margin);
            REG_MASK_LOW:    prdata = r_mask_lo;
            REG_MASK_HIGH:   prdata = 64'(r_mask_hi);
            default:         prdata = '0;
        endcase
    end

    acqt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_margin    (r_margin),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (w_f_ready),
        .o_cmd       (w_f_cmd)
    );

    acqt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_cmd),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_q_cmd)
    );

    acqt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_pop   (w_q_pop),
        .i_cmd       (w_q_cmd),
        .i_pair_mask ({r_mask_hi, r_mask_lo}),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
